// ----- rtl/ppsm_pkg.sv -----
`default_nettype none

package ppsm_pkg;

  // privacy levels
  localparam logic [2:0] LV_NORMAL   = 3'd0;
  localparam logic [2:0] LV_HUMAN    = 3'd1;
  localparam logic [2:0] LV_APPROACH = 3'd2;
  localparam logic [2:0] LV_SUSPECT  = 3'd3;
  localparam logic [2:0] LV_PROTECT  = 3'd4;
  localparam logic [2:0] LV_ALARM    = 3'd5;

  // command codes
  localparam logic [1:0] OP_RADAR   = 2'd0;
  localparam logic [1:0] OP_RESET   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_FORCE   = 2'd3;

  // target kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_MOVING = 2'd1;
  localparam logic [1:0] KIND_STATIC = 2'd2;
  localparam logic [1:0] KIND_BOTH   = 2'd3;

  // trend codes that matter
  localparam logic [2:0] TREND_APPROACH = 3'd1;
  localparam logic [2:0] TREND_LEAVING  = 3'd2;

  // configuration register indexes
  localparam logic [2:0] REG_NEAR_THR     = 3'd0;
  localparam logic [2:0] REG_SUSPECT_THR  = 3'd1;
  localparam logic [2:0] REG_PROTECT_THR  = 3'd2;
  localparam logic [2:0] REG_SUSPECT_HOLD = 3'd3;
  localparam logic [2:0] REG_PROTECT_HOLD = 3'd4;
  localparam logic [2:0] REG_DOWN_HOLD    = 3'd5;
  localparam logic [2:0] REG_PROTECT_MIN  = 3'd6;
  localparam logic [2:0] REG_CLEAR_HOLD   = 3'd7;

  // configuration reset values
  localparam logic [15:0] NEAR_THR_RST     = 16'd1500;
  localparam logic [15:0] SUSPECT_THR_RST  = 16'd900;
  localparam logic [15:0] PROTECT_THR_RST  = 16'd800;
  localparam logic [15:0] SUSPECT_HOLD_RST = 16'd2000;
  localparam logic [15:0] PROTECT_HOLD_RST = 16'd3500;
  localparam logic [15:0] DOWN_HOLD_RST    = 16'd2000;
  localparam logic [15:0] PROTECT_MIN_RST  = 16'd5000;
  localparam logic [15:0] CLEAR_HOLD_RST   = 16'd2000;

  typedef struct packed {
    logic [15:0] near_threshold_mm;
    logic [15:0] suspect_threshold_mm;
    logic [15:0] protect_threshold_mm;
    logic [15:0] suspect_dwell_ms;
    logic [15:0] protect_dwell_ms;
    logic [15:0] downgrade_dwell_ms;
    logic [15:0] protect_min_ms;
    logic [15:0] clear_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [1:0]  target_kind;
    logic [15:0] detect_cm;
    logic [15:0] moving_cm;
    logic [15:0] static_cm;
    logic [15:0] average_mm;
    logic        present_flag;
    logic [2:0]  trend_code;
    logic [2:0]  forced_level;
  } item_t;

  typedef struct packed {
    logic [2:0]  level;
    logic        level_changed;
    logic        release_ack;
    logic [31:0] level_hold_ms;
    logic [31:0] downgrade_elapsed_ms;
  } result_t;

  // cm to mm, saturating at the 16-bit ceiling
  function automatic logic [15:0] cm_to_mm(input logic [15:0] cm);
    logic [19:0] mm;
    mm = {1'b0, cm, 3'b000} + {3'b000, cm, 1'b0};
    return (mm[19:16] != 4'd0) ? 16'hFFFF : mm[15:0];
  endfunction

  // distance from the report fields, 0 when nothing applies
  function automatic logic [15:0] report_mm(input logic [1:0] kind, input logic [15:0] det,
                                            input logic [15:0] mov, input logic [15:0] sta);
    logic [15:0] pick;
    pick = 16'd0;
    if (det != 16'd0) begin
      pick = det;
    end else if (kind == KIND_MOVING && mov != 16'd0) begin
      pick = mov;
    end else if (kind == KIND_STATIC && sta != 16'd0) begin
      pick = sta;
    end else if (kind == KIND_BOTH) begin
      if (mov != 16'd0 && sta != 16'd0) begin
        pick = (mov < sta) ? mov : sta;
      end else if (mov != 16'd0) begin
        pick = mov;
      end else begin
        pick = sta;
      end
    end
    return cm_to_mm(pick);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/proximity_privacy_state_machine_top.sv -----
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// input     | in_valid / in_ready    | opcode, now_ms, target_kind, distances, flags
// result    | out_valid / out_ready  | level, level_changed, release_ack, hold times
// config    | cfg_we                 | cfg_index, cfg_data (16 bits)
//
// One item per cycle sustained while out_ready stays high; an item passes the input
// register, then the state update and result register in one pass, before its result
// is valid.
// Synchronous active-high reset returns config to defaults and the level to normal.
// A stalled result holds in the output register while the input register still
// takes one more item; further input waits until out_ready frees the pipeline.

module proximity_privacy_state_machine_top import ppsm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [1:0]  target_kind,
  input  wire logic [15:0] detect_cm,
  input  wire logic [15:0] moving_cm,
  input  wire logic [15:0] static_cm,
  input  wire logic [15:0] average_mm,
  input  wire logic        present_flag,
  input  wire logic [2:0]  trend_code,
  input  wire logic [2:0]  forced_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       level,
  output logic             level_changed,
  output logic             release_ack,
  output logic [31:0]      level_hold_ms,
  output logic [31:0]      downgrade_elapsed_ms,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t res;

  ppsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item moves from the input register to the result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.opcode       <= opcode;
      s1_item.now_ms       <= now_ms;
      s1_item.target_kind  <= target_kind;
      s1_item.detect_cm    <= detect_cm;
      s1_item.moving_cm    <= moving_cm;
      s1_item.static_cm    <= static_cm;
      s1_item.average_mm   <= average_mm;
      s1_item.present_flag <= present_flag;
      s1_item.trend_code   <= trend_code;
      s1_item.forced_level <= forced_level;
    end
  end

  ppsm_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level                <= res.level;
      level_changed        <= res.level_changed;
      release_ack          <= res.release_ack;
      level_hold_ms        <= res.level_hold_ms;
      downgrade_elapsed_ms <= res.downgrade_elapsed_ms;
    end
  end

  // release always lands in normal with a level change
  a_release_to_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_ack |-> level == LV_NORMAL && level_changed)
    else $error("release ack without return to normal");

  // a fresh level has zero hold time
  a_change_zero_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && level_changed |-> level_hold_ms == 32'd0)
    else $error("level change with nonzero hold time");

  // a held item in the input register is not dropped
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register lost an item");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- rtl/ppsm_cfg.sv -----
`default_nettype none

module ppsm_cfg import ppsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  // register file, one 16-bit register per index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_threshold_mm    <= NEAR_THR_RST;
      cfg.suspect_threshold_mm <= SUSPECT_THR_RST;
      cfg.protect_threshold_mm <= PROTECT_THR_RST;
      cfg.suspect_dwell_ms     <= SUSPECT_HOLD_RST;
      cfg.protect_dwell_ms     <= PROTECT_HOLD_RST;
      cfg.downgrade_dwell_ms   <= DOWN_HOLD_RST;
      cfg.protect_min_ms       <= PROTECT_MIN_RST;
      cfg.clear_hold_ms        <= CLEAR_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_THR:     cfg.near_threshold_mm    <= cfg_data;
        REG_SUSPECT_THR:  cfg.suspect_threshold_mm <= cfg_data;
        REG_PROTECT_THR:  cfg.protect_threshold_mm <= cfg_data;
        REG_SUSPECT_HOLD: cfg.suspect_dwell_ms     <= cfg_data;
        REG_PROTECT_HOLD: cfg.protect_dwell_ms     <= cfg_data;
        REG_DOWN_HOLD:    cfg.downgrade_dwell_ms   <= cfg_data;
        REG_PROTECT_MIN:  cfg.protect_min_ms       <= cfg_data;
        REG_CLEAR_HOLD:   cfg.clear_hold_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppsm_core.sv -----
`default_nettype none

module ppsm_core import ppsm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  // stored state
  logic [2:0]           level_reg;
  logic [TIME_BITS-1:0] entry_time, absent_since, suspect_since, downgrade_since;
  logic                 entry_valid, absent_valid, suspect_valid, downgrade_valid;

  // working copies for this item
  logic [2:0]           lv;
  logic                 ent_v, abs_v, sus_v, dg_v;
  logic                 ent_fresh, abs_fresh, sus_fresh, dg_fresh;
  logic                 ack, locked, absent, is_near, s_near, p_near;
  logic [15:0]          range_mm;
  logic [2:0]           forced;
  logic [TIME_BITS-1:0] now_t, ent_el_old, abs_el_old, sus_el_old, dg_el_old;
  logic [TIME_BITS-1:0] ent_el, abs_el, sus_el, dg_el;

  assign now_t      = TIME_BITS'(item.now_ms);
  assign ent_el_old = now_t - entry_time;
  assign abs_el_old = now_t - absent_since;
  assign sus_el_old = now_t - suspect_since;
  assign dg_el_old  = now_t - downgrade_since;

  // one step of the state machine, in the order the rules apply
  always_comb begin
    lv        = level_reg;
    ent_v     = entry_valid;
    abs_v     = absent_valid;
    sus_v     = suspect_valid;
    dg_v      = downgrade_valid;
    ent_fresh = 1'b0;
    abs_fresh = 1'b0;
    sus_fresh = 1'b0;
    dg_fresh  = 1'b0;
    ack       = 1'b0;
    abs_el    = '0;
    sus_el    = '0;
    dg_el     = '0;
    forced    = (item.forced_level > LV_ALARM) ? LV_ALARM : item.forced_level;
    absent    = !item.present_flag || item.target_kind == KIND_NONE;
    range_mm  = (item.average_mm != 16'd0) ? item.average_mm :
                report_mm(item.target_kind, item.detect_cm, item.moving_cm, item.static_cm);
    is_near   = range_mm != 16'd0 && range_mm <= cfg.near_threshold_mm;
    s_near    = range_mm != 16'd0 && range_mm <= cfg.suspect_threshold_mm;
    p_near    = range_mm != 16'd0 && range_mm <= cfg.protect_threshold_mm;
    locked    = level_reg == LV_PROTECT && entry_valid &&
                ent_el_old < TIME_BITS'(cfg.protect_min_ms);

    case (item.opcode)
      OP_RADAR: begin
        if (absent) begin
          // absence timing, back to normal once it has lasted
          if (!abs_v) begin
            abs_v = 1'b1;
            abs_fresh = 1'b1;
          end
          abs_el = abs_fresh ? '0 : abs_el_old;
          if (abs_el >= TIME_BITS'(cfg.clear_hold_ms)) begin
            if (lv != LV_NORMAL) begin
              lv = LV_NORMAL; ent_v = 1'b1; ent_fresh = 1'b1;
            end
            sus_v = 1'b0;
            dg_v  = 1'b0;
          end
        end else begin
          abs_v = 1'b0;
          if (!is_near) begin
            // far target: normal rises to human, higher levels step down to human after the hold
            sus_v = 1'b0;
            if (lv <= LV_HUMAN) begin
              if (lv != LV_HUMAN) begin
                lv = LV_HUMAN; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
              end
            end else if (!locked) begin
              if (!dg_v) begin
                dg_v = 1'b1; dg_fresh = 1'b1;
              end
              dg_el = dg_fresh ? '0 : dg_el_old;
              if (dg_el >= TIME_BITS'(cfg.downgrade_dwell_ms)) begin
                lv = LV_HUMAN; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
              end
            end
          end else begin
            // near target
            if (lv == LV_NORMAL) begin
              lv = LV_HUMAN; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
            end
            if (lv < LV_SUSPECT) begin
              dg_v = 1'b0;
            end
            if (item.trend_code == TREND_APPROACH && lv < LV_APPROACH) begin
              lv = LV_APPROACH; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
            end

            if (s_near) begin
              dg_v = 1'b0;
              if (!sus_v) begin
                sus_v = 1'b1; sus_fresh = 1'b1;
              end
              sus_el = sus_fresh ? '0 : sus_el_old;
              if (sus_el >= TIME_BITS'(cfg.suspect_dwell_ms) && lv < LV_SUSPECT) begin
                lv = LV_SUSPECT; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
              end
            end else begin
              sus_v = 1'b0;
              if (lv >= LV_SUSPECT && !locked) begin
                if (!dg_v) begin
                  dg_v = 1'b1; dg_fresh = 1'b1;
                end
                dg_el = dg_fresh ? '0 : dg_el_old;
                if (dg_el >= TIME_BITS'(cfg.downgrade_dwell_ms) && lv != LV_APPROACH) begin
                  lv = LV_APPROACH; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
                end
              end
            end

            // protect entry
            if (p_near && sus_v && sus_el >= TIME_BITS'(cfg.protect_dwell_ms) &&
                lv != LV_PROTECT) begin
              lv = LV_PROTECT; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
            end

            // leaving trend steps down to human
            if (item.trend_code == TREND_LEAVING && !s_near && lv >= LV_APPROACH &&
                !locked) begin
              if (!dg_v) begin
                dg_v = 1'b1; dg_fresh = 1'b1;
              end
              dg_el = dg_fresh ? '0 : dg_el_old;
              if (dg_el >= TIME_BITS'(cfg.downgrade_dwell_ms)) begin
                lv = LV_HUMAN; ent_v = 1'b1; ent_fresh = 1'b1; dg_v = 1'b0;
              end
            end
          end
        end
      end
      OP_RESET: begin
        if (lv != LV_NORMAL) begin
          lv = LV_NORMAL; ent_v = 1'b1; ent_fresh = 1'b1;
        end
        abs_v = 1'b0; sus_v = 1'b0; dg_v = 1'b0;
      end
      OP_RELEASE: begin
        if (lv == LV_PROTECT || lv == LV_ALARM) begin
          lv = LV_NORMAL; ent_v = 1'b1; ent_fresh = 1'b1;
          abs_v = 1'b0; sus_v = 1'b0; dg_v = 1'b0;
          ack = 1'b1;
        end
      end
      OP_FORCE: begin
        if (lv != forced) begin
          lv = forced; ent_v = 1'b1; ent_fresh = 1'b1;
        end
        abs_v = 1'b0; sus_v = 1'b0; dg_v = 1'b0;
      end
      default: ;
    endcase

    ent_el = ent_fresh ? '0 : ent_el_old;
    dg_el  = dg_fresh ? '0 : dg_el_old;

    res.level                = lv;
    res.level_changed        = lv != level_reg;
    res.release_ack          = ack;
    res.level_hold_ms        = ent_v ? 32'(ent_el) : 32'd0;
    res.downgrade_elapsed_ms = dg_v ? 32'(dg_el) : 32'd0;
  end

  // state update on each transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg       <= LV_NORMAL;
      entry_valid     <= 1'b0;
      absent_valid    <= 1'b0;
      suspect_valid   <= 1'b0;
      downgrade_valid <= 1'b0;
    end else if (fire) begin
      level_reg       <= lv;
      entry_valid     <= ent_v;
      absent_valid    <= abs_v;
      suspect_valid   <= sus_v;
      downgrade_valid <= dg_v;
    end
  end

  // timestamps, loaded with the current time when a timer restarts
  always_ff @(posedge clk) begin
    if (fire) begin
      if (ent_fresh) entry_time      <= now_t;
      if (abs_fresh) absent_since    <= now_t;
      if (sus_fresh) suspect_since   <= now_t;
      if (dg_fresh)  downgrade_since <= now_t;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  import ppsm_pkg::*;

  localparam int LIMIT_CYCLES = 300000;

  // trend and level codes the package does not name
  localparam logic [2:0] TREND_NONE      = 3'd0;
  localparam logic [2:0] TREND_STABLE    = 3'd3;
  localparam logic [2:0] TREND_UNKNOWN   = 3'd4;
  localparam logic [2:0] TREND_UNDEFINED = 3'd7;
  localparam logic [2:0] LEVEL_UNDEFINED = 3'd7;

  localparam cfg_t DEFAULT_SETTINGS = '{
    NEAR_THR_RST, SUSPECT_THR_RST, PROTECT_THR_RST, SUSPECT_HOLD_RST,
    PROTECT_HOLD_RST, DOWN_HOLD_RST, PROTECT_MIN_RST, CLEAR_HOLD_RST
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  item_t drv = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  logic [2:0] level;
  logic level_changed;
  logic release_ack;
  logic [31:0] level_hold_ms;
  logic [31:0] downgrade_elapsed_ms;

  // privacy state mirror, tracked per accepted transfer
  cfg_t shadow = DEFAULT_SETTINGS;
  logic [2:0] lvl_now = LV_NORMAL;
  logic [31:0] entry_t = '0;
  logic [31:0] absent_t = '0;
  logic [31:0] susp_t = '0;
  logic [31:0] down_t = '0;
  bit entry_v = 1'b0;
  bit absent_v = 1'b0;
  bit susp_v = 1'b0;
  bit down_v = 1'b0;

  result_t status_q[$];
  logic [31:0] clock_ms = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int hold_left = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_changes = 0;
  int n_acks = 0;
  int n_writes = 0;
  int cycles = 0;
  int level_hits[8];

  proximity_privacy_state_machine_top i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .opcode               (drv.opcode),
    .now_ms               (drv.now_ms),
    .target_kind          (drv.target_kind),
    .detect_cm            (drv.detect_cm),
    .moving_cm            (drv.moving_cm),
    .static_cm            (drv.static_cm),
    .average_mm           (drv.average_mm),
    .present_flag         (drv.present_flag),
    .trend_code           (drv.trend_code),
    .forced_level         (drv.forced_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .level                (level),
    .level_changed        (level_changed),
    .release_ack          (release_ack),
    .level_hold_ms        (level_hold_ms),
    .downgrade_elapsed_ms (downgrade_elapsed_ms),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, status_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // level change: restart entry time, drop downgrade timing
  function automatic void go_level(input logic [2:0] next, input logic [31:0] now);
    if (lvl_now != next) begin
      lvl_now = next;
      entry_t = now;
      entry_v = 1'b1;
      down_v = 1'b0;
    end
  endfunction

  function automatic void drop_timers();
    absent_v = 1'b0;
    susp_v = 1'b0;
    down_v = 1'b0;
  endfunction

  // starts downgrade timing if idle, true once the hold has run out
  function automatic bit down_ready(input logic [31:0] now);
    if (!down_v) begin
      down_t = now;
      down_v = 1'b1;
    end
    return (now - down_t) >= shadow.downgrade_dwell_ms;
  endfunction

  // next privacy status for one transfer
  function automatic result_t advance_privacy(input item_t it);
    result_t r;
    logic [2:0] prior;
    logic [2:0] target;
    logic [31:0] now;
    logic [15:0] range_mm;
    logic [15:0] cm;
    logic [19:0] mm20;
    bit ack, is_near, s_near, p_near, locked;
    prior = lvl_now;
    now = it.now_ms;
    ack = 1'b0;
    case (it.opcode)
      OP_RADAR: begin
        if (!it.present_flag || it.target_kind == KIND_NONE) begin
          // nobody there: count absence, clear out once it lasts
          if (!absent_v) begin
            absent_t = now;
            absent_v = 1'b1;
          end
          if ((now - absent_t) >= shadow.clear_hold_ms) begin
            go_level(LV_NORMAL, now);
            susp_v = 1'b0;
            down_v = 1'b0;
          end
        end else begin
          absent_v = 1'b0;
          // distance: average first, else from the report fields
          range_mm = it.average_mm;
          if (range_mm == 16'd0) begin
            cm = 16'd0;
            if (it.detect_cm != 16'd0) begin
              cm = it.detect_cm;
            end else if (it.target_kind == KIND_MOVING) begin
              cm = it.moving_cm;
            end else if (it.target_kind == KIND_STATIC) begin
              cm = it.static_cm;
            end else if (it.moving_cm == 16'd0) begin
              cm = it.static_cm;
            end else if (it.static_cm == 16'd0 || it.moving_cm < it.static_cm) begin
              cm = it.moving_cm;
            end else begin
              cm = it.static_cm;
            end
            mm20 = cm * 20'd10;
            range_mm = (mm20 > 20'd65535) ? 16'hFFFF : mm20[15:0];
          end
          is_near = range_mm != 16'd0 && range_mm <= shadow.near_threshold_mm;
          s_near = range_mm != 16'd0 && range_mm <= shadow.suspect_threshold_mm;
          p_near = range_mm != 16'd0 && range_mm <= shadow.protect_threshold_mm;
          locked = lvl_now == LV_PROTECT && entry_v &&
                   (now - entry_t) < shadow.protect_min_ms;
          if (!is_near) begin
            susp_v = 1'b0;
            if (lvl_now <= LV_HUMAN) begin
              go_level(LV_HUMAN, now);
            end else if (!locked) begin
              if (down_ready(now)) go_level(LV_HUMAN, now);
            end
          end else begin
            if (lvl_now == LV_NORMAL) go_level(LV_HUMAN, now);
            if (lvl_now < LV_SUSPECT) down_v = 1'b0;
            if (it.trend_code == TREND_APPROACH && lvl_now < LV_APPROACH) begin
              go_level(LV_APPROACH, now);
            end
            if (s_near) begin
              down_v = 1'b0;
              if (!susp_v) begin
                susp_t = now;
                susp_v = 1'b1;
              end
              if ((now - susp_t) >= shadow.suspect_dwell_ms && lvl_now < LV_SUSPECT) begin
                go_level(LV_SUSPECT, now);
              end
            end else begin
              susp_v = 1'b0;
              if (lvl_now >= LV_SUSPECT && !locked) begin
                if (down_ready(now)) go_level(LV_APPROACH, now);
              end
            end
            if (p_near && susp_v && (now - susp_t) >= shadow.protect_dwell_ms) begin
              go_level(LV_PROTECT, now);
            end
            // leaving outside suspect range steps down after the hold
            if (it.trend_code == TREND_LEAVING && !s_near && lvl_now >= LV_APPROACH &&
                !locked) begin
              if (down_ready(now)) go_level(LV_HUMAN, now);
            end
          end
        end
      end
      OP_RESET: begin
        go_level(LV_NORMAL, now);
        drop_timers();
      end
      OP_RELEASE: begin
        if (lvl_now == LV_ALARM || lvl_now == LV_PROTECT) begin
          go_level(LV_NORMAL, now);
          drop_timers();
          ack = 1'b1;
        end
      end
      OP_FORCE: begin
        target = (it.forced_level > LV_ALARM) ? LV_ALARM : it.forced_level;
        go_level(target, now);
        drop_timers();
      end
      default: ;
    endcase
    r.level = lvl_now;
    r.level_changed = lvl_now != prior;
    r.release_ack = ack;
    r.level_hold_ms = entry_v ? now - entry_t : 32'd0;
    r.downgrade_elapsed_ms = down_v ? now - down_t : 32'd0;
    return r;
  endfunction

  // one input transfer, called at a falling edge
  task automatic send_item(input item_t it);
    drv = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    status_q.push_back(advance_privacy(it));
    n_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // sender pauses until every pending status is back
  task automatic drain_results();
    in_valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    n_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_NEAR_THR, c.near_threshold_mm);
    write_reg(REG_SUSPECT_THR, c.suspect_threshold_mm);
    write_reg(REG_PROTECT_THR, c.protect_threshold_mm);
    write_reg(REG_SUSPECT_HOLD, c.suspect_dwell_ms);
    write_reg(REG_PROTECT_HOLD, c.protect_dwell_ms);
    write_reg(REG_DOWN_HOLD, c.downgrade_dwell_ms);
    write_reg(REG_PROTECT_MIN, c.protect_min_ms);
    write_reg(REG_CLEAR_HOLD, c.clear_hold_ms);
    shadow = c;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.near_threshold_mm = 16'($urandom_range(500, 3000));
    c.suspect_threshold_mm = 16'($urandom_range(200, c.near_threshold_mm));
    c.protect_threshold_mm = 16'($urandom_range(100, c.suspect_threshold_mm));
    c.suspect_dwell_ms = 16'($urandom_range(0, 4000));
    c.protect_dwell_ms = 16'($urandom_range(0, 6000));
    c.downgrade_dwell_ms = 16'($urandom_range(0, 4000));
    c.protect_min_ms = 16'($urandom_range(0, 8000));
    c.clear_hold_ms = 16'($urandom_range(0, 4000));
    return c;
  endfunction

  function automatic item_t random_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t report_item(input logic [31:0] now, input logic [1:0] kind,
                                        input logic [15:0] det, input logic [15:0] mov,
                                        input logic [15:0] sta, input logic [15:0] avg,
                                        input logic pres, input logic [2:0] trend);
    item_t it;
    it = random_item();
    it.opcode = OP_RADAR;
    it.now_ms = now;
    it.target_kind = kind;
    it.detect_cm = det;
    it.moving_cm = mov;
    it.static_cm = sta;
    it.average_mm = avg;
    it.present_flag = pres;
    it.trend_code = trend;
    return it;
  endfunction

  function automatic item_t command_item(input logic [1:0] op, input logic [31:0] now,
                                         input logic [2:0] forced);
    item_t it;
    it = random_item();
    it.opcode = op;
    it.now_ms = now;
    it.forced_level = forced;
    return it;
  endfunction

  // radar report at the scene clock, distance encoded one of several ways
  function automatic item_t radar_at(input int mm, input logic [2:0] trend);
    item_t it;
    logic [15:0] cm;
    logic [15:0] spare;
    it = random_item();
    cm = 16'(mm / 10);
    it.opcode = OP_RADAR;
    it.now_ms = clock_ms;
    it.present_flag = 1'b1;
    it.trend_code = trend;
    case ($urandom_range(4))
      0: begin
        it.average_mm = 16'(mm);
        if (it.target_kind == KIND_NONE) it.target_kind = KIND_BOTH;
      end
      1: begin
        it.average_mm = 16'd0;
        it.detect_cm = cm;
        it.target_kind = 2'($urandom_range(1, 3));
      end
      2: begin
        it.average_mm = 16'd0;
        it.detect_cm = 16'd0;
        it.target_kind = KIND_MOVING;
        it.moving_cm = cm;
      end
      3: begin
        it.average_mm = 16'd0;
        it.detect_cm = 16'd0;
        it.target_kind = KIND_STATIC;
        it.static_cm = cm;
      end
      default: begin
        // both kinds, nearer one or the only one present
        it.average_mm = 16'd0;
        it.detect_cm = 16'd0;
        it.target_kind = KIND_BOTH;
        spare = $urandom_range(1) ? 16'd0 : cm + 16'($urandom_range(0, 200));
        if ($urandom_range(1)) begin
          it.moving_cm = cm;
          it.static_cm = spare;
        end else begin
          it.moving_cm = spare;
          it.static_cm = cm;
        end
      end
    endcase
    return it;
  endfunction

  function automatic logic [2:0] pick_trend(input logic [2:0] usual);
    return ($urandom_range(9) < 7) ? usual : 3'($urandom_range(7));
  endfunction

  // approach, dwell, retreat and leave, with commands and noise mixed in
  task automatic play_scene();
    int steps, i, pick, mm;
    logic [2:0] heading;
    item_t it;
    steps = $urandom_range(10, 40);
    case ($urandom_range(3))
      0: clock_ms = $urandom;
      1: clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(30000));
      default: ;
    endcase
    mm = $urandom_range(1000, 3500);
    for (i = 0; i < steps; i++) begin
      clock_ms += 32'($urandom_range(0, 800));
      pick = $urandom_range(99);
      it = random_item();
      if (pick < 5) begin
        // fully random item
      end else if (pick < 12) begin
        case ($urandom_range(3))
          0: it.opcode = OP_RESET;
          3: it.opcode = OP_FORCE;
          default: it.opcode = OP_RELEASE;
        endcase
        it.now_ms = clock_ms;
      end else if (i >= steps - 3) begin
        it.opcode = OP_RADAR;
        it.now_ms = clock_ms;
        if ($urandom_range(1)) it.present_flag = 1'b0;
        else it.target_kind = KIND_NONE;
      end else begin
        if (i < steps / 3) begin
          mm -= int'($urandom_range(0, 400));
          heading = pick_trend(TREND_APPROACH);
        end else if (i < 2 * steps / 3) begin
          mm += int'($urandom_range(0, 200)) - 100;
          heading = 3'($urandom_range(7));
        end else begin
          mm += int'($urandom_range(0, 500));
          heading = pick_trend(TREND_LEAVING);
        end
        if (mm < 30) mm = 30;
        if (mm > 7000) mm = 7000;
        it = radar_at(mm, heading);
      end
      send_item(it);
    end
  endtask

  // receiver: random hold-off, or a long stall on request
  always @(negedge clk) begin
    if (stall_request != 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // compare each result transfer with the oldest pending status
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      n_changes += level_changed;
      n_acks += release_ack;
      level_hits[level]++;
      if (status_q.size() == 0) begin
        flag_mismatch("unrequested result, level", '0, level);
      end else begin
        want = status_q.pop_front();
        n_checked++;
        if (level !== want.level) flag_mismatch("level", want.level, level);
        if (level_changed !== want.level_changed) begin
          flag_mismatch("level_changed", want.level_changed, level_changed);
        end
        if (release_ack !== want.release_ack) begin
          flag_mismatch("release_ack", want.release_ack, release_ack);
        end
        if (level_hold_ms !== want.level_hold_ms) begin
          flag_mismatch("level_hold_ms", want.level_hold_ms, level_hold_ms);
        end
        if (downgrade_elapsed_ms !== want.downgrade_elapsed_ms) begin
          flag_mismatch("downgrade_elapsed_ms", want.downgrade_elapsed_ms,
                        downgrade_elapsed_ms);
        end
      end
    end
  end

  // walk through every command, every distance source and the hold timers
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // release while normal does nothing
    send_item(command_item(OP_RELEASE, 32'd100, LEVEL_UNDEFINED));
    // absence by flag, then by kind once the clear hold ran out
    send_item(report_item(32'd200, KIND_MOVING, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, TREND_NONE));
    send_item(report_item(32'd2300, KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                          TREND_UNDEFINED));
    // detect distance wins over the kind fields
    send_item(report_item(32'd2400, KIND_BOTH, 16'd120, 16'd0, 16'd0, 16'd0, 1'b1,
                          TREND_NONE));
    // moving distance with approach trend, suspect timing starts
    send_item(report_item(32'd2500, KIND_MOVING, 16'd0, 16'd50, 16'd10, 16'd0, 1'b1,
                          TREND_APPROACH));
    send_item(report_item(32'd4600, KIND_STATIC, 16'd0, 16'd5, 16'd60, 16'd0, 1'b1,
                          TREND_STABLE));
    // both kinds take the nearer, protect entered
    send_item(report_item(32'd6100, KIND_BOTH, 16'd0, 16'd70, 16'd40, 16'd0, 1'b1,
                          TREND_UNKNOWN));
    // far while protect minimum is still running: locked
    send_item(report_item(32'd6200, KIND_BOTH, 16'd0, 16'd0, 16'd300, 16'd0, 1'b1,
                          TREND_LEAVING));
    send_item(report_item(32'd11200, KIND_STATIC, 16'd0, 16'd0, 16'd300, 16'd0, 1'b1,
                          TREND_LEAVING));
    send_item(report_item(32'd13300, KIND_STATIC, 16'd0, 16'd0, 16'd300, 16'd0, 1'b1,
                          TREND_NONE));
    // forced level saturates, release acts in alarm and protect only
    send_item(command_item(OP_FORCE, 32'd13400, LEVEL_UNDEFINED));
    send_item(command_item(OP_RELEASE, 32'd13500, LV_NORMAL));
    send_item(command_item(OP_FORCE, 32'd13600, LV_PROTECT));
    send_item(command_item(OP_RELEASE, 32'd13700, LV_ALARM));
    send_item(command_item(OP_FORCE, 32'd13800, LV_SUSPECT));
    send_item(command_item(OP_RELEASE, 32'd13900, LV_HUMAN));
    send_item(command_item(OP_RESET, 32'd14000, LV_APPROACH));
    // no distance anywhere, then saturated distances
    send_item(report_item(32'd14100, KIND_BOTH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, TREND_NONE));
    send_item(report_item(32'd14200, KIND_MOVING, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1,
                          TREND_APPROACH));
    send_item(report_item(32'd14300, KIND_STATIC, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1,
                          TREND_NONE));
    // timestamps wrapping through zero
    send_item(report_item(32'hFFFF_FF00, KIND_MOVING, 16'd0, 16'd1, 16'd0, 16'd0, 1'b1,
                          TREND_APPROACH));
    send_item(report_item(32'h0000_0800, KIND_MOVING, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1,
                          TREND_UNDEFINED));
    send_item(report_item(32'h0000_1000, KIND_BOTH, 16'd0, 16'd0, 16'd0, 16'd1000, 1'b1,
                          TREND_LEAVING));
    send_item(report_item(32'h0000_2000, KIND_BOTH, 16'd0, 16'd0, 16'd0, 16'd1000, 1'b1,
                          TREND_LEAVING));
    send_item(report_item(32'h0000_4000, KIND_BOTH, 16'd0, 16'd0, 16'd0, 16'd1000, 1'b1,
                          TREND_LEAVING));
  endtask

  // all-ones, all-zeros, mixed and random register settings
  task automatic test_register_extremes();
    cfg_t c;
    int k;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    for (k = 0; k < 4; k++) begin
      case (k)
        0: c = '1;
        1: c = '0;
        2: begin
          // everything near, no hold times at all
          c = '0;
          c.near_threshold_mm = '1;
          c.suspect_threshold_mm = '1;
          c.protect_threshold_mm = '1;
        end
        default: c = random_settings();
      endcase
      drain_results();
      load_settings(c);
      repeat (2) play_scene();
    end
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items,
                                     input cfg_t c);
    int start;
    drain_results();
    load_settings(c);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = n_sent;
    while (n_sent - start < n_items) play_scene();
  endtask

  // long output stall while the sender keeps offering
  task automatic test_output_stall();
    int i;
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 60;
    for (i = 0; i < 30; i++) begin
      clock_ms += 32'($urandom_range(0, 600));
      send_item(radar_at($urandom_range(100, 2500), 3'($urandom_range(7))));
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_random_traffic(31, 86, 210, random_settings());
    test_random_traffic(86, 31, 210, random_settings());
    test_random_traffic(0, 0, 210, DEFAULT_SETTINGS);
    test_output_stall();
    drain_results();
    $display("sent %0d reports and commands, checked %0d results, %0d register writes",
             n_sent, n_checked, n_writes);
    $display("%0d level changes, %0d release acks, protect seen %0d times, alarm %0d times",
             n_changes, n_acks, level_hits[LV_PROTECT], level_hits[LV_ALARM]);
    if (n_errors == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, status_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
